/* hw/rtl/spq_pkg.sv */
package spq_pkg;

  // Operation carried with each input item.
  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // Outcome reported with each result item.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DEQ_EMPTY = 2'd1,
    STATUS_ENQ_FULL  = 2'd2
  } status_t;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W    = 1;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_FIFO_MODE = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // register the accepted item
    logic exec;  // apply it to the cell row and load the result register
  } ctl_t;

endpackage

/* hw/rtl/stable_priority_queue_unit.sv */
// Stable priority queue of (id, priority) entries held in a row of DEPTH cells.
// An enqueue (tuser 0) is placed behind every stored entry of equal or higher
// priority, or at the tail when fifo_mode is set; a dequeue (tuser 1) returns
// the head. Every item gives exactly one result item carrying a status in
// out_tuser: ok, dequeue from an empty queue, or enqueue dropped on a full
// queue; is_empty and occupancy describe the queue after the item. Each item
// is first registered, then executed in a step in which all cells compare
// and shift together; a new item is taken only after the previous one has
// been executed. The result register lets the next item be taken while the
// previous result still waits. Configuration writes are meant for idle time.
module stable_priority_queue_unit #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned PRIO_BITS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: item_id, item_priority
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((ID_BITS+PRIO_BITS+7)/8)*8-1:0] in_tdata,
  // in_tuser: cmd
  input  logic [0:0]                        in_tuser,
  // out_tdata: out_id, out_priority, is_empty, occupancy
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((ID_BITS+PRIO_BITS+1+$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata,
  // out_tuser: status
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [spq_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [spq_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [spq_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import spq_pkg::*;

  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W     = ID_BITS + PRIO_BITS + 1 + CNT_W;
  localparam int unsigned OUT_TD_W  = ((OUT_W + 7) / 8) * 8;
  localparam int unsigned EMPTY_BIT = ID_BITS + PRIO_BITS;
  localparam int unsigned OCC_LSB   = ID_BITS + PRIO_BITS + 1;

  ctl_t                 ctl;
  logic                 fifo_mode_r;
  logic [ID_BITS-1:0]   res_id;
  logic [PRIO_BITS-1:0] res_prio;
  status_t              res_status;
  logic                 res_empty;
  logic [CNT_W-1:0]     res_occ;

  // Configuration register; writes complete in the access phase.
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == REG_FIFO_MODE)) begin
      fifo_mode_r <= cfg_pwdata[0];
    end
  end
  assign cfg_prdata = (cfg_paddr == REG_FIFO_MODE) ? CFG_DATA_W'(fifo_mode_r) : '0;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  spq_datapath #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS),
    .CNT_W     (CNT_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .fifo_mode  (fifo_mode_r),
    .in_cmd     (cmd_t'(in_tuser[0])),
    .in_id      (in_tdata[ID_BITS-1:0]),
    .in_prio    (in_tdata[ID_BITS+PRIO_BITS-1:ID_BITS]),
    .res_id     (res_id),
    .res_prio   (res_prio),
    .res_status (res_status),
    .res_empty  (res_empty),
    .res_occ    (res_occ)
  );

  // Result packing, first field in the lowest bits.
  assign out_tdata = OUT_TD_W'({res_occ, res_empty, res_prio, res_id});
  assign out_tuser = res_status;

  // An accepted item blocks the input until it has been executed.
  a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again before the previous item was executed");

  // An empty-queue dequeue reports an empty queue and no entries.
  a_deq_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STATUS_DEQ_EMPTY)) |->
    (out_tdata[EMPTY_BIT] && (out_tdata[OCC_LSB+CNT_W-1:OCC_LSB] == '0)))
    else $error("dequeue from empty reported with entries stored");

  // A dropped enqueue happens only on a full queue.
  a_enq_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STATUS_ENQ_FULL)) |->
    (out_tdata[OCC_LSB+CNT_W-1:OCC_LSB] == CNT_W'(DEPTH)))
    else $error("enqueue dropped while the queue was not full");

  // Reported occupancy never exceeds the cell count.
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OCC_LSB+CNT_W-1:OCC_LSB] <= CNT_W'(DEPTH)))
    else $error("occupancy above depth");

endmodule

/* hw/rtl/spq_ctrl.sv */
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output spq_pkg::ctl_t ctl
);
  import spq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_valid_r;

  // The item is taken in idle; it is executed once the result register is free.
  assign ctl.take = in_tvalid && in_tready_r;
  assign ctl.exec = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_valid_r;

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctl.take) begin
            state_r     <= S_EXEC;
            in_tready_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (ctl.exec) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b1;
        end
      endcase
      if (ctl.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/spq_datapath.sv */
module spq_datapath #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned PRIO_BITS = 3,
  parameter int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spq_pkg::ctl_t         ctl,
  input  logic                  fifo_mode,
  input  spq_pkg::cmd_t         in_cmd,
  input  logic [ID_BITS-1:0]    in_id,
  input  logic [PRIO_BITS-1:0]  in_prio,
  output logic [ID_BITS-1:0]    res_id,
  output logic [PRIO_BITS-1:0]  res_prio,
  output spq_pkg::status_t      res_status,
  output logic                  res_empty,
  output logic [CNT_W-1:0]      res_occ
);
  import spq_pkg::*;

  // Registered item under execution.
  cmd_t                 item_cmd_r;
  logic [ID_BITS-1:0]   item_id_r;
  logic [PRIO_BITS-1:0] item_prio_r;

  // Cell row, head at cell 0; only cells below the fill count hold entries.
  logic [ID_BITS-1:0]   slot_id_r    [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio_r  [DEPTH];
  logic [ID_BITS-1:0]   slot_id_nxt  [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio_nxt[DEPTH];
  logic [CNT_W-1:0]     fill_r;
  logic [CNT_W-1:0]     fill_nxt;

  // Result register.
  logic [ID_BITS-1:0]   res_id_r,     res_id_nxt;
  logic [PRIO_BITS-1:0] res_prio_r,   res_prio_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [CNT_W-1:0]     res_occ_r;

  // Per-cell insert candidates and the cells behind the insert point.
  logic [DEPTH-1:0] stop;
  logic [DEPTH-1:0] seen;

  // A cell stops the search at the fill point, or in priority mode where a
  // stored entry has lower priority than the new one.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      stop[k] = (CNT_W'(k) == fill_r) ||
                (!fifo_mode && (CNT_W'(k) < fill_r) && (slot_prio_r[k] < item_prio_r));
    end
  end

  // A cell lies behind the insert point when any earlier cell stops the search.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      seen[k] = 1'b0;
      for (int j = 0; j < k; j++) begin
        seen[k] = seen[k] | stop[j];
      end
    end
  end

  // Next state of the cell row and the result of the executed item.
  always_comb begin
    fill_nxt       = fill_r;
    res_id_nxt     = '0;
    res_prio_nxt   = '0;
    res_status_nxt = STATUS_OK;
    for (int k = 0; k < DEPTH; k++) begin
      slot_id_nxt[k]   = slot_id_r[k];
      slot_prio_nxt[k] = slot_prio_r[k];
    end
    if (item_cmd_r == CMD_DEQ) begin
      if (fill_r == '0) begin
        res_status_nxt = STATUS_DEQ_EMPTY;
      end else begin
        res_id_nxt   = slot_id_r[0];
        res_prio_nxt = slot_prio_r[0];
        for (int k = 0; k < DEPTH - 1; k++) begin
          slot_id_nxt[k]   = slot_id_r[k+1];
          slot_prio_nxt[k] = slot_prio_r[k+1];
        end
        fill_nxt = fill_r - CNT_W'(1);
      end
    end else if (fill_r == CNT_W'(DEPTH)) begin
      res_status_nxt = STATUS_ENQ_FULL;
    end else begin
      if (stop[0]) begin
        slot_id_nxt[0]   = item_id_r;
        slot_prio_nxt[0] = item_prio_r;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (seen[k]) begin
          slot_id_nxt[k]   = slot_id_r[k-1];
          slot_prio_nxt[k] = slot_prio_r[k-1];
        end else if (stop[k]) begin
          slot_id_nxt[k]   = item_id_r;
          slot_prio_nxt[k] = item_prio_r;
        end
      end
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.exec) begin
      fill_r <= fill_nxt;
    end
  end

  // Item register, cell row and result register.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      item_cmd_r  <= in_cmd;
      item_id_r   <= in_id;
      item_prio_r <= in_prio;
    end
    if (ctl.exec) begin
      for (int k = 0; k < DEPTH; k++) begin
        slot_id_r[k]   <= slot_id_nxt[k];
        slot_prio_r[k] <= slot_prio_nxt[k];
      end
      res_id_r     <= res_id_nxt;
      res_prio_r   <= res_prio_nxt;
      res_status_r <= res_status_nxt;
      res_occ_r    <= fill_nxt;
    end
  end

  assign res_id     = res_id_r;
  assign res_prio   = res_prio_r;
  assign res_status = res_status_r;
  assign res_occ    = res_occ_r;
  assign res_empty  = (res_occ_r == '0);

endmodule
